@@ hdl/rmv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 1024;

	localparam int SAMPLE_W   = 32;
	localparam int COUNT_W    = 32;
	localparam int SUM_W      = 64;
	localparam int MEAN_W     = 32;
	localparam int M2_W       = 63;
	localparam int FILL_OUT_W = 11;
	localparam int DIFF_W     = 33;
	localparam int PROD_W     = 64;
	localparam int FRAC_W     = 16;
	localparam int TERM_W     = PROD_W - FRAC_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [M2_W-1:0]    M2_MAX    = '1;

	typedef struct packed {
		logic load_sample;
		logic div_start;
		logic commit;
		logic mean_load;
		logic mul;
		logic m2_update;
		logic out_load;
	} rmv_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sat;
		logic first;
		logic out_free;
	} rmv_sts_t;

endpackage

`default_nettype wire

@@ hdl/rmv_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rmv_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [rmv_pkg::SAMPLE_W-1:0]   sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ hdl/rmv_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rmv_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [rmv_pkg::COUNT_W-1:0]            sample_count;
	logic signed [rmv_pkg::SUM_W-1:0]       running_sum;
	logic signed [rmv_pkg::MEAN_W-1:0]      running_mean;
	logic [rmv_pkg::M2_W-1:0]               sum_sq_dev;
	logic [rmv_pkg::FILL_OUT_W-1:0]         history_fill;
	logic                                   saturated;

	modport source (output valid, output sample_count, output running_sum,
		output running_mean, output sum_sq_dev, output history_fill,
		output saturated, input ready);
	modport sink (input valid, input sample_count, input running_sum,
		input running_mean, input sum_sq_dev, input history_fill,
		input saturated, output ready);
endinterface

`default_nettype wire

@@ hdl/running_mean_variance_tracker_core.sv @@
// Each request runs two 32-step passes of the shared radix-2 divider (old mean,
// new mean), then the multiply and the M2 update; the first sample skips the
// multiply and M2 update, and a saturated count takes only the first pass.
// A request is taken only in idle, after the previous one is loaded into the output register.
// A new request is taken while the previous result still waits in the output register.
// Reset (arst_n low): count, sum, M2 and fill level clear; the output register empties.
`timescale 1ns / 1ps
`default_nettype none

module running_mean_variance_tracker_core #(
	parameter int unsigned HISTORY_DEPTH = rmv_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rmv_in_if.sink     samples,
	rmv_out_if.source  stats
);
	rmv_pkg::rmv_cmd_t cmd;
	rmv_pkg::rmv_sts_t sts;
	logic              in_ready;

	assign samples.ready = in_ready;

	rmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmv_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (samples.sample),
		.cmd    (cmd),
		.sts    (sts),
		.stats  (stats)
	);

endmodule

`default_nettype wire

@@ hdl/rmv_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// radix-2 restoring divide, signed 64 / unsigned 32, quotient known to fit 32 bits
module rmv_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [rmv_pkg::SUM_W-1:0]       dividend,
	input  wire logic [rmv_pkg::COUNT_W-1:0]     divisor,
	output logic                                 done,
	output logic [rmv_pkg::MEAN_W-1:0]           quotient
);
	localparam int QUO_W = rmv_pkg::MEAN_W;
	localparam int DEN_W = rmv_pkg::COUNT_W;
	localparam int CNT_W = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DEN_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;

	logic [rmv_pkg::SUM_W-1:0] mag;
	logic [DEN_W:0]            trial;
	logic [DEN_W:0]            diff;
	logic                      ge;

	assign mag   = dividend[rmv_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[rmv_pkg::SUM_W-1];
			rem_q <= mag[rmv_pkg::SUM_W-1:QUO_W];
			quo_q <= mag[QUO_W-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

@@ hdl/rmv_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmv_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rmv_pkg::rmv_sts_t  sts,
	output rmv_pkg::rmv_cmd_t       cmd
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV1   = 3'd1;
	localparam logic [2:0] ST_START2 = 3'd2;
	localparam logic [2:0] ST_DIV2   = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_UPD    = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					cmd.div_start   = 1'b1;
					state_nxt       = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (sts.div_done) begin
					if (sts.sat) begin
						cmd.mean_load = 1'b1;
						state_nxt     = ST_OUT;
					end else begin
						cmd.commit = 1'b1;
						state_nxt  = ST_START2;
					end
				end
			end
			ST_START2: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV2;
			end
			ST_DIV2: begin
				if (sts.div_done) begin
					cmd.mean_load = 1'b1;
					state_nxt     = sts.first ? ST_OUT : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				cmd.m2_update = 1'b1;
				state_nxt     = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

@@ hdl/rmv_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmv_dp #(
	parameter int unsigned HISTORY_DEPTH = rmv_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [rmv_pkg::SAMPLE_W-1:0]    sample,
	input  wire rmv_pkg::rmv_cmd_t               cmd,
	output rmv_pkg::rmv_sts_t                    sts,
	rmv_out_if.source                            stats
);
	localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int S_W     = rmv_pkg::SAMPLE_W;
	localparam int D_W     = rmv_pkg::DIFF_W;
	localparam int MAG_W   = rmv_pkg::DIFF_W - 1;
	localparam int SUM_W   = rmv_pkg::SUM_W;
	localparam int M2_W    = rmv_pkg::M2_W;
	localparam int TERM_W  = rmv_pkg::TERM_W;
	localparam int COUNT_W = rmv_pkg::COUNT_W;

	// architectural state
	logic [COUNT_W-1:0]  count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [M2_W-1:0]     m2_q;
	logic [FILL_W-1:0]   fill_q;

	// working registers
	logic [S_W-1:0]              sample_q;
	logic                        sat_q;
	logic [D_W-1:0]              d1_q;
	logic [D_W-1:0]              d2_q;
	logic [rmv_pkg::MEAN_W-1:0]  mean_q;
	logic [rmv_pkg::PROD_W-1:0]  prod_q;
	logic                        neg_q;

	// result register
	logic                                out_valid_q;
	logic [COUNT_W-1:0]                  out_count_q;
	logic [SUM_W-1:0]                    out_sum_q;
	logic [rmv_pkg::MEAN_W-1:0]          out_mean_q;
	logic [M2_W-1:0]                     out_m2_q;
	logic [rmv_pkg::FILL_OUT_W-1:0]      out_fill_q;
	logic                                out_sat_q;

	logic                        div_done;
	logic [rmv_pkg::MEAN_W-1:0]  div_quo;
	logic [COUNT_W-1:0]          div_den;
	logic [D_W-1:0]              dev;
	logic [D_W-1:0]              d1_neg;
	logic [D_W-1:0]              d2_neg;
	logic [MAG_W-1:0]            mag1;
	logic [MAG_W-1:0]            mag2;
	logic [TERM_W-1:0]           term;
	logic [M2_W:0]               m2_add;
	logic [M2_W-1:0]             m2_nxt;

	assign div_den = (count_q == '0) ? COUNT_W'(1) : count_q;

	rmv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign dev    = {sample_q[S_W-1], sample_q} - {div_quo[S_W-1], div_quo};
	assign d1_neg = -d1_q;
	assign d2_neg = -d2_q;
	assign mag1   = d1_q[D_W-1] ? d1_neg[MAG_W-1:0] : d1_q[MAG_W-1:0];
	assign mag2   = d2_q[D_W-1] ? d2_neg[MAG_W-1:0] : d2_q[MAG_W-1:0];
	assign term   = prod_q[rmv_pkg::PROD_W-1:rmv_pkg::FRAC_W];
	assign m2_add = {1'b0, m2_q} + (M2_W + 1)'(term);

	always_comb begin
		m2_nxt = m2_q;
		if (term != '0) begin
			if (neg_q) begin
				m2_nxt = ((M2_W + 1)'(term) > {1'b0, m2_q}) ? '0 : m2_q - M2_W'(term);
			end else begin
				m2_nxt = m2_add[M2_W] ? rmv_pkg::M2_MAX : m2_add[M2_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			m2_q        <= '0;
			fill_q      <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_sample) begin
				sat_q <= (count_q == rmv_pkg::COUNT_MAX);
			end
			if (cmd.commit) begin
				sum_q   <= sum_q + {{(SUM_W - S_W){sample_q[S_W-1]}}, sample_q};
				count_q <= count_q + 1'b1;
				if (fill_q < FILL_W'(HISTORY_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.m2_update) begin
				m2_q <= m2_nxt;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (stats.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample;
		end
		if (cmd.commit) begin
			d1_q <= dev;
		end
		if (cmd.mean_load) begin
			mean_q <= div_quo;
			d2_q   <= dev;
		end
		if (cmd.mul) begin
			prod_q <= mag1 * mag2;
			neg_q  <= d1_q[D_W-1] ^ d2_q[D_W-1];
		end
		if (cmd.out_load) begin
			out_count_q <= count_q;
			out_sum_q   <= sum_q;
			out_mean_q  <= mean_q;
			out_m2_q    <= m2_q;
			out_fill_q  <= rmv_pkg::FILL_OUT_W'(fill_q);
			out_sat_q   <= sat_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.sat      = sat_q;
	assign sts.first    = (count_q == COUNT_W'(1));
	assign sts.out_free = !out_valid_q || stats.ready;

	assign stats.valid        = out_valid_q;
	assign stats.sample_count = out_count_q;
	assign stats.running_sum  = out_sum_q;
	assign stats.running_mean = out_mean_q;
	assign stats.sum_sq_dev   = out_m2_q;
	assign stats.history_fill = out_fill_q;
	assign stats.saturated    = out_sat_q;

endmodule

`default_nettype wire
